FILE: design/msenv_pkg.sv
package msenv_pkg;

  // Number of stage words and fixed-point fraction of the interpolation scale.
  localparam int unsigned MAX_STAGES = 4;
  localparam int unsigned FRAC_BITS  = 12;
  localparam int unsigned QUO_W      = FRAC_BITS + 1;
  localparam int unsigned DIV_CNT_W  = $clog2(QUO_W);
  localparam int unsigned STAGE_W    = $clog2(MAX_STAGES);
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned WORD_W     = 50;
  localparam int unsigned PADDR_W    = 6;

  // Register indexes on the configuration port (byte address is 8 * index).
  localparam logic [2:0] REG_COUNT = 3'd0;
  localparam logic [2:0] REG_WORD0 = 3'd1;
  localparam logic [2:0] REG_WORD1 = 3'd2;
  localparam logic [2:0] REG_WORD2 = 3'd3;
  localparam logic [2:0] REG_WORD3 = 3'd4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_GOTO  = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_RESP
  } state_e;

  // One stage word, least significant field last.
  typedef struct packed {
    logic                      held;
    logic [MS_W-1:0]           ms;
    logic signed [LEVEL_W-1:0] end_lvl;
    logic                      from_cur;
    logic signed [LEVEL_W-1:0] start_lvl;
  } stage_word_t;

  // A count of zero acts as one, a count above the stage array as its size.
  function automatic logic [2:0] eff_count(input logic [2:0] cnt);
    logic [2:0] res;
    res = cnt;
    if (cnt == 3'd0) begin
      res = 3'd1;
    end else if (cnt > 3'(MAX_STAGES)) begin
      res = 3'(MAX_STAGES);
    end
    return res;
  endfunction

endpackage

FILE: design/multi_stage_envelope_generator_core.sv
// Channel   | Direction | Signals
// ----------+-----------+-----------------------------------------------------------
// request   | in        | in_valid_i, in_ready_o, opcode_i, step_ms_i, target_stage_i
// result    | out       | out_valid_o, out_ready_i, level_o, active_o, stage_now_o,
//           |           | started_o, stage_changes_o, completed_now_o
// config    | in/out    | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Start, go-to-stage and idle ticks go from accept straight to the result state.
// A running tick passes the check state once per stage it looks at, then, for a
// timed stage still in progress, runs the shared restoring divider, one multiply
// and one add.
// Reset clears the control, configuration and envelope state at once; there is no clearing pass.
// A request is taken only in the idle state; a stalled result holds the next one back.
module multi_stage_envelope_generator_core import msenv_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Request channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                opcode_i,
  input  logic [MS_W-1:0]           step_ms_i,
  input  logic [2:0]                target_stage_i,
  // Result channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [LEVEL_W-1:0] level_o,
  output logic                      active_o,
  output logic [STAGE_W-1:0]        stage_now_o,
  output logic                      started_o,
  output logic [2:0]                stage_changes_o,
  output logic                      completed_now_o,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);

  state_e state_q, state_d;

  logic [2:0]                stage_count_q;
  stage_word_t               words_q [MAX_STAGES];

  logic [TIME_W-1:0]         time_now_q;
  logic [TIME_W-1:0]         ref_time_q;
  logic signed [LEVEL_W-1:0] ref_level_q;
  logic signed [LEVEL_W-1:0] held_level_q;
  logic [STAGE_W-1:0]        stage_idx_q;
  logic                      running_q;

  logic                      started_q;
  logic [2:0]                changes_q;
  logic                      done_q;

  // Divider and interpolation datapath.
  logic [MS_W-1:0]           div_ms_q;
  logic [MS_W:0]             rem_q;
  logic [QUO_W-1:0]          quo_q;
  logic [DIV_CNT_W-1:0]      div_cnt_q;
  logic signed [LEVEL_W-1:0] start_q;
  logic signed [LEVEL_W:0]   diff_q;
  logic signed [LEVEL_W+QUO_W:0] prod_q;

  // Result register.
  logic                      out_valid_q;
  logic signed [LEVEL_W-1:0] out_level_q;
  logic                      out_active_q;
  logic [STAGE_W-1:0]        out_stage_q;
  logic                      out_started_q;
  logic [2:0]                out_changes_q;
  logic                      out_done_q;

  logic                      in_fire;
  logic                      out_load;
  logic                      out_free;
  logic                      cfg_write;
  logic [2:0]                reg_idx;
  logic [2:0]                count_eff;
  stage_word_t               cur_word;
  logic [TIME_W-1:0]         elapsed;
  logic                      crossed;
  logic                      last_stage;
  logic                      flat_level;
  logic signed [LEVEL_W-1:0] interp_start;
  logic                      div_ge;
  logic [MS_W:0]             div_sub;
  logic                      goto_ok;

  // Configuration port decode.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[5:3];
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    case (reg_idx)
      REG_COUNT: prdata = {61'd0, stage_count_q};
      REG_WORD0: prdata = {14'd0, words_q[0]};
      REG_WORD1: prdata = {14'd0, words_q[1]};
      REG_WORD2: prdata = {14'd0, words_q[2]};
      REG_WORD3: prdata = {14'd0, words_q[3]};
      default:   prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_count_q <= 3'd1;
      for (int i = 0; i < MAX_STAGES; i++) begin
        words_q[i] <= '0;
      end
    end else if (cfg_write) begin
      case (reg_idx)
        REG_COUNT: stage_count_q <= pwdata[2:0];
        REG_WORD0: words_q[0]    <= pwdata[WORD_W-1:0];
        REG_WORD1: words_q[1]    <= pwdata[WORD_W-1:0];
        REG_WORD2: words_q[2]    <= pwdata[WORD_W-1:0];
        REG_WORD3: words_q[3]    <= pwdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode of the running stage and the stage-crossing compare.
  assign count_eff    = eff_count(stage_count_q);
  assign cur_word     = words_q[stage_idx_q];
  assign elapsed      = time_now_q - ref_time_q;
  assign crossed      = !cur_word.held && (elapsed > {16'd0, cur_word.ms});
  assign last_stage   = ({1'b0, stage_idx_q} + 3'd1) >= count_eff;
  assign flat_level   = cur_word.held || (cur_word.ms == '0);
  assign interp_start = cur_word.from_cur ? ref_level_q : cur_word.start_lvl;
  assign goto_ok      = target_stage_i < count_eff;

  // One restoring divide step.
  assign div_ge  = rem_q >= {1'b0, div_ms_q};
  assign div_sub = div_ge ? (rem_q - {1'b0, div_ms_q}) : rem_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if ((opcode_i == OP_TICK) && running_q) begin
            state_d = ST_CHECK;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_CHECK: begin
        if (crossed) begin
          if (last_stage) begin
            state_d = ST_RESP;
          end
        end else if (flat_level) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_ADD;
      ST_ADD: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_RESP: out_load   = out_free;
      default: ;
    endcase
  end

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Envelope state: request handling and stage walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_now_q   <= '0;
      ref_time_q   <= '0;
      ref_level_q  <= '0;
      held_level_q <= '0;
      stage_idx_q  <= '0;
      running_q    <= 1'b0;
      started_q    <= 1'b0;
      changes_q    <= '0;
      done_q       <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            started_q <= 1'b0;
            changes_q <= '0;
            done_q    <= 1'b0;
            case (opcode_i)
              OP_START: begin
                time_now_q  <= '0;
                ref_time_q  <= '0;
                ref_level_q <= words_q[0].from_cur ? held_level_q
                                                   : words_q[0].start_lvl;
                held_level_q <= words_q[0].from_cur ? held_level_q
                                                    : words_q[0].start_lvl;
                stage_idx_q <= '0;
                running_q   <= 1'b1;
                started_q   <= 1'b1;
              end
              OP_GOTO: begin
                ref_level_q <= held_level_q;
                ref_time_q  <= time_now_q;
                changes_q   <= 3'd1;
                running_q   <= goto_ok;
                stage_idx_q <= goto_ok ? target_stage_i[STAGE_W-1:0] : '0;
              end
              OP_TICK: begin
                time_now_q <= time_now_q + {16'd0, step_ms_i};
              end
              default: ;
            endcase
          end
        end
        ST_CHECK: begin
          if (crossed) begin
            held_level_q <= cur_word.end_lvl;
            if (last_stage) begin
              running_q   <= 1'b0;
              stage_idx_q <= '0;
              done_q      <= 1'b1;
            end else begin
              ref_time_q  <= ref_time_q + {16'd0, cur_word.ms};
              ref_level_q <= cur_word.end_lvl;
              stage_idx_q <= stage_idx_q + 1'b1;
              changes_q   <= changes_q + 3'd1;
            end
          end else if (flat_level) begin
            held_level_q <= cur_word.end_lvl;
          end
        end
        ST_ADD: begin
          held_level_q <= start_q + prod_q[FRAC_BITS +: LEVEL_W];
        end
        default: ;
      endcase
    end
  end

  // Interpolation datapath: scale = (elapsed << FRAC_BITS) / ms, one bit a cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_CHECK: begin
        div_ms_q  <= cur_word.ms;
        rem_q     <= {1'b0, elapsed[MS_W-1:0]};
        quo_q     <= '0;
        div_cnt_q <= DIV_CNT_W'(FRAC_BITS);
        start_q   <= interp_start;
        diff_q    <= (LEVEL_W+1)'(cur_word.end_lvl) - (LEVEL_W+1)'(interp_start);
      end
      ST_DIV: begin
        rem_q     <= {div_sub[MS_W-1:0], 1'b0};
        quo_q     <= {quo_q[QUO_W-2:0], div_ge};
        div_cnt_q <= div_cnt_q - 1'b1;
      end
      ST_MUL: begin
        prod_q <= diff_q * $signed({1'b0, quo_q});
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_level_q   <= held_level_q;
      out_active_q  <= running_q;
      out_stage_q   <= running_q ? stage_idx_q : '0;
      out_started_q <= started_q;
      out_changes_q <= changes_q;
      out_done_q    <= done_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign level_o         = out_level_q;
  assign active_o        = out_active_q;
  assign stage_now_o     = out_stage_q;
  assign started_o       = out_started_q;
  assign stage_changes_o = out_changes_q;
  assign completed_now_o = out_done_q;

`ifndef ASSERT_OFF
  // An inactive result always reports stage zero.
  a_idle_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !active_o) |-> (stage_now_o == '0))
    else $error("inactive result with nonzero stage");

  // A completion leaves the envelope inactive.
  a_done_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && completed_now_o) |-> !active_o)
    else $error("completion reported while active");

  // A start result is active in stage zero with no stage change.
  a_start_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && started_o) |->
      (active_o && (stage_now_o == '0) && (stage_changes_o == '0)))
    else $error("start result inconsistent");

  // The divider never runs with a zero duration.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_ms_q != '0))
    else $error("divide by zero duration");
`endif

endmodule

FILE: bench/multi_stage_envelope_generator_core_test.sv
`timescale 1ns / 100ps

module multi_stage_envelope_generator_core_test;
  import msenv_pkg::*;

  // Opcode that the block treats as a no-operation.
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    logic signed [LEVEL_W-1:0] level;
    logic                      active;
    logic [STAGE_W-1:0]        stage_now;
    logic                      started;
    logic [2:0]                changes;
    logic                      completed;
  } envelope_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  wire                       in_ready;
  logic [1:0]                opcode = OP_TICK;
  logic [MS_W-1:0]           step_ms = '0;
  logic [2:0]                target_stage = '0;

  wire                       out_valid;
  logic                      out_ready = 1'b0;
  wire signed [LEVEL_W-1:0]  level;
  wire                       active;
  wire [STAGE_W-1:0]         stage_now;
  wire                       started;
  wire [2:0]                 stage_changes;
  wire                       completed_now;

  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [63:0]               pwdata = '0;
  wire [63:0]                prdata;
  wire                       pready;

  // Shadow of the configuration registers.
  logic [2:0]  cfg_count = 3'd1;
  stage_word_t cfg_word [MAX_STAGES];

  // Shadow of the envelope state.
  logic [TIME_W-1:0] env_time = '0;
  logic [TIME_W-1:0] env_ref_time = '0;
  int                env_ref_level = 0;
  int                env_held_level = 0;
  int unsigned       env_stage = 0;
  bit                env_running = 1'b0;

  envelope_result_t pending_results[$];
  int unsigned fail_count = 0;
  int unsigned reports = 0;
  bit          quiet_mode = 1'b0;
  int unsigned ready_hold = 0;
  int unsigned tick_scale = 20;

  multi_stage_envelope_generator_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .step_ms_i       (step_ms),
    .target_stage_i  (target_stage),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .level_o         (level),
    .active_o        (active),
    .stage_now_o     (stage_now),
    .started_o       (started),
    .stage_changes_o (stage_changes),
    .completed_now_o (completed_now),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("multi_stage_envelope_generator_core_test: FAIL");
    $finish;
  end

  // Linear interpolation inside one stage at the given elapsed time.
  function automatic int ramp_level(stage_word_t sw, logic [TIME_W-1:0] elapsed);
    int first;
    int last;
    logic [TIME_W-1:0] t;
    longint unsigned num;
    longint unsigned scale;
    longint prod;
    first = sw.from_cur ? env_ref_level : int'(sw.start_lvl);
    last = int'(sw.end_lvl);
    if (sw.held || sw.ms == '0) begin
      return last;
    end
    t = (elapsed > TIME_W'(sw.ms)) ? TIME_W'(sw.ms) : elapsed;
    num = t;
    num = num << FRAC_BITS;
    scale = num / longint'(sw.ms);
    prod = longint'(last - first) * longint'(scale);
    return first + int'(prod >>> FRAC_BITS);
  endfunction

  // Applies one request to the shadow state and returns the result it causes.
  function automatic envelope_result_t advance_envelope(logic [1:0] op, logic [MS_W-1:0] step,
                                                        logic [2:0] target);
    envelope_result_t res;
    stage_word_t sw;
    int unsigned count;
    int lvl;
    logic [TIME_W-1:0] elapsed;
    bit searching;
    bit was_start;
    bit done;
    int unsigned changes;
    count = (cfg_count == 3'd0) ? 1 : ((cfg_count > MAX_STAGES) ? MAX_STAGES : cfg_count);
    was_start = 1'b0;
    done = 1'b0;
    changes = 0;
    case (op)
      OP_START: begin
        sw = cfg_word[0];
        env_time = '0;
        env_ref_time = '0;
        env_ref_level = sw.from_cur ? env_held_level : int'(sw.start_lvl);
        env_held_level = env_ref_level;
        env_stage = 0;
        env_running = 1'b1;
        was_start = 1'b1;
      end
      OP_GOTO: begin
        env_ref_level = env_held_level;
        env_ref_time = env_time;
        changes = 1;
        if (target < count) begin
          env_stage = target;
          env_running = 1'b1;
        end else begin
          env_stage = 0;
          env_running = 1'b0;
        end
      end
      OP_TICK: begin
        env_time = env_time + TIME_W'(step);
        if (env_running) begin
          lvl = env_held_level;
          searching = 1'b1;
          // Walk through every stage whose duration has run out.
          while (searching) begin
            sw = cfg_word[env_stage];
            elapsed = env_time - env_ref_time;
            if (!sw.held && elapsed > TIME_W'(sw.ms)) begin
              if (env_stage + 1 >= count) begin
                lvl = int'(sw.end_lvl);
                env_running = 1'b0;
                env_stage = 0;
                done = 1'b1;
                searching = 1'b0;
              end else begin
                lvl = ramp_level(sw, TIME_W'(sw.ms));
                env_ref_time = env_ref_time + TIME_W'(sw.ms);
                env_ref_level = lvl;
                env_stage++;
                changes++;
              end
            end else begin
              lvl = ramp_level(sw, elapsed);
              searching = 1'b0;
            end
          end
          env_held_level = lvl;
        end
      end
      default: begin
      end
    endcase
    res.level = LEVEL_W'(env_held_level);
    res.active = env_running;
    res.stage_now = env_running ? STAGE_W'(env_stage) : '0;
    res.started = was_start;
    res.changes = 3'(changes);
    res.completed = done;
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_mode) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Result side backpressure.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (quiet_mode || $urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  // Compare every accepted result with the oldest pending prediction.
  always @(posedge clk) begin
    envelope_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (reports < REPORT_LIMIT) begin
          reports++;
          $display("unexpected result: level %0d active %0b stage %0d", level, active,
                   stage_now);
        end
      end else begin
        want = pending_results.pop_front();
        if (want.level !== level || want.active !== active || want.stage_now !== stage_now ||
            want.started !== started || want.changes !== stage_changes ||
            want.completed !== completed_now) begin
          fail_count++;
          if (reports < REPORT_LIMIT) begin
            reports++;
            $display("mismatch at %0t: level %0d/%0d active %0b/%0b stage %0d/%0d", $realtime,
                     want.level, level, want.active, active, want.stage_now, stage_now);
            $display("  started %0b/%0b changes %0d/%0d completed %0b/%0b (expected/actual)",
                     want.started, started, want.changes, stage_changes, want.completed,
                     completed_now);
          end
        end
      end
    end
  end

  // Send one request and record the result it should cause.
  task automatic send_request(logic [1:0] op, logic [MS_W-1:0] step, logic [2:0] target);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    step_ms <= step;
    target_stage <= target;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(advance_envelope(op, step, target));
  endtask

  // Stop sending and let every pending result drain.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // One write on the configuration port: setup then access.
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_COUNT) begin
      cfg_count = value[2:0];
    end else begin
      cfg_word[idx - REG_WORD0] = value[WORD_W-1:0];
    end
  endtask

  function automatic stage_word_t make_word(logic signed [15:0] first, logic from_cur,
                                            logic signed [15:0] last, logic [15:0] ms,
                                            logic held);
    stage_word_t sw;
    sw.start_lvl = first;
    sw.from_cur = from_cur;
    sw.end_lvl = last;
    sw.ms = ms;
    sw.held = held;
    return sw;
  endfunction

  function automatic logic [15:0] random_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return 16'h8000;
    end else if (r < 30) begin
      return 16'h7FFF;
    end
    return 16'($urandom);
  endfunction

  function automatic stage_word_t random_word();
    int unsigned r;
    logic [15:0] ms;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      ms = '0;
    end else if (r < 15) begin
      ms = 16'hFFFF;
    end else if (r < 22) begin
      ms = 16'($urandom);
    end else begin
      ms = 16'($urandom_range(1, 4 * tick_scale));
    end
    return make_word(random_level(), 1'($urandom), random_level(), ms,
                     $urandom_range(0, 99) < 15);
  endfunction

  function automatic logic [MS_W-1:0] random_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return '0;
    end else if (r < 18) begin
      return MS_W'($urandom);
    end else if (r < 21) begin
      return '1;
    end
    return MS_W'($urandom_range(1, tick_scale));
  endfunction

  // Reset settings: single zero-duration stage, an idle tick and an ignored opcode.
  task automatic test_reset_settings();
    send_request(OP_TICK, 16'd3, 3'd0);
    send_request(OP_START, 16'd0, 3'd0);
    send_request(OP_TICK, 16'd1, 3'd0);
    send_request(OP_NONE, 16'hFFFF, 3'd7);
    drain_results();
  endtask

  // Four stages: timed ramp, zero duration, long ramp from current level, held stage.
  task automatic test_stage_walk();
    write_reg(REG_COUNT, 64'd4);
    write_reg(REG_WORD0, 64'(make_word(16'sh8000, 1'b0, 16'sh7FFF, 16'd100, 1'b0)));
    write_reg(REG_WORD1, 64'(make_word(16'sd0, 1'b1, 16'sh8000, 16'd0, 1'b0)));
    write_reg(REG_WORD2, 64'(make_word(16'sd0, 1'b1, 16'sd1000, 16'hFFFF, 1'b0)));
    write_reg(REG_WORD3, 64'(make_word(16'sd7, 1'b0, -16'sd5, 16'd10, 1'b1)));
    send_request(OP_START, 16'd0, 3'd0);
    send_request(OP_TICK, 16'd0, 3'd0);
    send_request(OP_TICK, 16'd50, 3'd0);
    send_request(OP_TICK, 16'd60, 3'd0);
    send_request(OP_TICK, 16'hFFFF, 3'd0);
    send_request(OP_TICK, 16'hFFFF, 3'd0);
    send_request(OP_GOTO, 16'd0, 3'd1);
    send_request(OP_GOTO, 16'd0, 3'd4);
    send_request(OP_TICK, 16'd5, 3'd0);
    send_request(OP_GOTO, 16'd0, 3'd3);
    send_request(OP_TICK, 16'd1, 3'd0);
    send_request(OP_NONE, 16'd0, 3'd0);
    drain_results();
  endtask

  // Count of zero and a count above the stage array, start from current on stage 0.
  task automatic test_count_limits();
    write_reg(REG_COUNT, 64'd0);
    write_reg(REG_WORD0, 64'(make_word(16'sh1234, 1'b1, -16'sd300, 16'd40, 1'b0)));
    send_request(OP_START, 16'd0, 3'd0);
    send_request(OP_TICK, 16'd20, 3'd0);
    send_request(OP_TICK, 16'd30, 3'd0);
    drain_results();
    write_reg(REG_COUNT, 64'd7);
    write_reg(REG_WORD3, 64'({WORD_W{1'b1}}));
    send_request(OP_START, 16'd0, 3'd0);
    send_request(OP_GOTO, 16'd0, 3'd7);
    send_request(OP_GOTO, 16'd0, 3'd3);
    send_request(OP_TICK, 16'hFFFF, 3'd0);
    drain_results();
  endtask

  // One random setting followed by mostly start-then-tick sequences.
  task automatic run_random_phase(logic [2:0] count, int unsigned items);
    int unsigned r;
    int unsigned eff;
    logic [2:0] target;
    write_reg(REG_COUNT, 64'(count));
    write_reg(REG_WORD0, 64'(random_word()));
    write_reg(REG_WORD1, 64'(random_word()));
    write_reg(REG_WORD2, 64'(random_word()));
    write_reg(REG_WORD3, 64'(random_word()));
    eff = (count == 3'd0) ? 1 : ((count > MAX_STAGES) ? MAX_STAGES : count);
    send_request(OP_START, random_step(), 3'($urandom));
    for (int unsigned i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if ((!env_running && r < 35) || r < 5) begin
        send_request(OP_START, random_step(), 3'($urandom));
      end else if (r < 11) begin
        target = ($urandom_range(0, 99) < 75) ? 3'($urandom_range(0, eff - 1)) : 3'($urandom);
        send_request(OP_GOTO, random_step(), target);
      end else if (r < 13) begin
        send_request(OP_NONE, random_step(), 3'($urandom));
      end else begin
        send_request(OP_TICK, random_step(), 3'($urandom));
      end
    end
    drain_results();
  endtask

  task automatic test_random_settings();
    logic [2:0] counts [12] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd4, 3'd0,
                                3'd5, 3'd7, 3'd3, 3'd2, 3'd4, 3'd1};
    int unsigned scales [4] = '{3, 15, 60, 400};
    for (int unsigned p = 0; p < 12; p++) begin
      quiet_mode = (p % 4 == 3);
      tick_scale = scales[$urandom_range(0, 3)];
      run_random_phase(counts[p], 152);
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < MAX_STAGES; i++) begin
      cfg_word[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_stage_walk();
    test_count_limits();
    test_random_settings();

    drain_results();
    if (pending_results.size() != 0) begin
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("multi_stage_envelope_generator_core_test: PASS");
    end else begin
      $display("multi_stage_envelope_generator_core_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/msenv_pkg.sv
design/multi_stage_envelope_generator_core.sv
bench/multi_stage_envelope_generator_core_test.sv
